[rtl/core/fde_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// fde_pkg
// Shared types, register codes and arithmetic helpers for the echo unit.
// ============================================================================
package fde_pkg;

    // Configuration port
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIX_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN = 2'd2;

    // Line length register: holds up to 65536, so 17 bits always suffice
    localparam int LEN_W = 17;
    localparam int LEN_RESET = 24000;

    localparam logic [15:0] MIX_RESET = 16'd16384;
    localparam logic [16:0] MIX_FULL = 17'd32768;
    localparam logic [14:0] FB_RESET = 15'd16384;
    localparam logic [14:0] FB_MAX = 15'd32440;

    // Result queue
    localparam int OUT_DEPTH = 4;
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    typedef struct packed {
        logic [15:0] mix;
        logic [14:0] fb;
    } t_gains;

    // Clamp a 19-bit signed value to the 16-bit full-scale range
    function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
        logic signed [15:0] res;
        if (v > 19'sd32767) begin
            res = 16'sh7FFF;
        end else if (v < -19'sd32768) begin
            res = 16'sh8000;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

endpackage

[rtl/core/fde_ram.sv]
`timescale 1ns / 1ps
// ============================================================================
// fde_ram
// Generic single-port RAM, one access per cycle, registered read data.
// ============================================================================
module fde_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32768
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/fde_fifo.sv]
`timescale 1ns / 1ps
// ============================================================================
// fde_fifo
// Small synchronous queue built from registers, with an occupancy count.
// ============================================================================
module fde_fifo #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic                       o_empty,
    output logic                       o_full,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + AW'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    assign o_data  = r_mem[r_rp];
    assign o_count = r_cnt;

endmodule

[rtl/core/fde_front.sv]
`timescale 1ns / 1ps
// ============================================================================
// fde_front
// Input side: takes samples, tags each with its delay-line position and
// advances the circular pointer.
// ============================================================================
module fde_front #(
    parameter int MAX_DELAY_SAMPLES = 32768
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_push,
    input  logic signed [15:0]                        i_sample,
    input  logic [fde_pkg::LEN_W-1:0]                 i_len,
    input  logic                                      i_q_full,
    output logic                                      o_q_push,
    output logic [16+$clog2(MAX_DELAY_SAMPLES)-1:0]   o_q_data
);

    localparam int PW = $clog2(MAX_DELAY_SAMPLES);
    localparam int CW = (PW + 1 > fde_pkg::LEN_W) ? PW + 1 : fde_pkg::LEN_W;

    logic [PW-1:0] r_ptr, n_ptr;
    logic [PW:0]   ptr_inc;
    logic          accept, wrap;

    assign accept  = i_push && !i_q_full;
    assign ptr_inc = {1'b0, r_ptr} + (PW + 1)'(1);
    // Wrap once the next position reaches the length; a shortened line
    // still uses the current position once
    assign wrap    = (CW'(ptr_inc) >= CW'(i_len));
    assign n_ptr   = wrap ? '0 : ptr_inc[PW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
        end else if (accept) begin
            r_ptr <= n_ptr;
        end
    end

    assign o_q_push = accept;
    assign o_q_data = {i_sample, r_ptr};

endmodule

[rtl/core/fde_back.sv]
`timescale 1ns / 1ps
// ============================================================================
// fde_back
// Execution side: reads the delay line, writes back the feedback sum and
// forms the dry/wet mix over a short pipeline.
// ============================================================================
module fde_back #(
    parameter int MAX_DELAY_SAMPLES = 32768
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_q_empty,
    input  logic [16+$clog2(MAX_DELAY_SAMPLES)-1:0]   i_q_data,
    output logic                                      o_q_pop,
    input  fde_pkg::t_gains                           i_gains,
    input  logic [fde_pkg::OUT_CNT_W-1:0]             i_out_count,
    output logic                                      o_out_push,
    output logic signed [15:0]                        o_out_data
);

    localparam int PW = $clog2(MAX_DELAY_SAMPLES);

    logic signed [15:0] q_sample;
    logic [PW-1:0]      q_pos;
    logic               issue;

    // Stage 1: read data back from the RAM, write-back in the same slot
    logic               r_s1_v;
    logic signed [15:0] r_s1_sample;
    logic [PW-1:0]      r_s1_pos;
    logic [PW:0]        r_fill;

    logic [15:0]        ram_rdata;
    logic signed [15:0] d;
    logic signed [31:0] fb_prod;
    logic signed [17:0] wr_sum;
    logic signed [15:0] wr;
    logic [15:0]        dry;
    logic signed [32:0] dry_prod, wet_prod;

    // Stage 2: mix sum and clamp
    logic               r_s2_v;
    logic signed [32:0] r_s2_dry, r_s2_wet;
    logic signed [33:0] mix_sum;

    assign {q_sample, q_pos} = i_q_data;

    // The RAM port alternates read and write: no item is issued while stage 1 holds one.
    // Room is reserved in the result queue before an item starts.
    assign issue = !i_q_empty && !r_s1_v &&
                   (({1'b0, i_out_count} + {{fde_pkg::OUT_CNT_W{1'b0}}, r_s2_v})
                    < (fde_pkg::OUT_CNT_W + 1)'(fde_pkg::OUT_DEPTH));
    assign o_q_pop = issue;

    // Positions at or above the fill count were never written since reset
    assign d = ({1'b0, r_s1_pos} < r_fill) ? $signed(ram_rdata) : 16'sd0;

    assign fb_prod = $signed({1'b0, i_gains.fb}) * d;
    assign wr_sum  = {{2{r_s1_sample[15]}}, r_s1_sample} + {fb_prod[31], fb_prod[31:15]};
    assign wr      = fde_pkg::sat16({wr_sum[17], wr_sum});

    assign dry      = 16'(fde_pkg::MIX_FULL - {1'b0, i_gains.mix});
    assign dry_prod = $signed({1'b0, dry}) * r_s1_sample;
    assign wet_prod = $signed({1'b0, i_gains.mix}) * d;

    fde_ram #(
        .WIDTH (16),
        .DEPTH (MAX_DELAY_SAMPLES)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (r_s1_v),
        .i_addr  (r_s1_v ? r_s1_pos : q_pos),
        .i_wdata (wr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_fill <= '0;
        end else begin
            r_s1_v <= issue;
            r_s2_v <= r_s1_v;
            if (r_s1_v && ({1'b0, r_s1_pos} == r_fill)) begin
                r_fill <= r_fill + (PW + 1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s1_sample <= q_sample;
            r_s1_pos    <= q_pos;
        end
        if (r_s1_v) begin
            r_s2_dry <= dry_prod;
            r_s2_wet <= wet_prod;
        end
    end

    assign mix_sum    = {r_s2_dry[32], r_s2_dry} + {r_s2_wet[32], r_s2_wet};
    assign o_out_push = r_s2_v;
    assign o_out_data = fde_pkg::sat16(mix_sum[33:15]);

endmodule

[rtl/core/feedback_delay_echo_unit.sv]
`timescale 1ns / 1ps
// ============================================================================
// feedback_delay_echo_unit
// Q1.15 feedback delay-line echo with dry/wet mix.
// ============================================================================
// Usage:
//   Input queue: drive i_sample_in and raise push; the item is taken on an
//   edge where full is low. Result queue: o_sample_out holds the oldest
//   result while empty is low; pop takes it. One result per input item.
//   Config: i_cfg_we with i_cfg_index/i_cfg_data, applied at the edge,
//   values saturated (length 1..MAX_DELAY_SAMPLES, mix 0..32768, feedback
//   0..32440). Write only while the unit is idle.
//   An accepted item passes the middle queue, stage 1, stage 2 and the
//   result queue. A new item starts only once the last has left stage 1:
//   the single-port delay RAM serves one read then one write-back per item.
//   A 2-entry queue sits between the input side and the execution side;
//   a 4-entry result queue absorbs receiver stalls. When the receiver
//   stalls, the execution side stops once the result queue is committed,
//   then the middle queue fills and full goes high.
//   Reset: pointer to zero, registers to defaults (length 24000 or the
//   depth if smaller, mix and feedback 0.5). The delay line reads as zero
//   until written, tracked by a fill count, so no clearing pass is needed.
// ============================================================================
module feedback_delay_echo_unit #(
    parameter int MAX_DELAY_SAMPLES = 32768
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input queue
    input  logic                             push,
    output logic                             full,
    input  logic signed [15:0]               i_sample_in,
    // result queue
    output logic                             empty,
    input  logic                             pop,
    output logic signed [15:0]               o_sample_out,
    // configuration
    input  logic                             i_cfg_we,
    input  logic [fde_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [fde_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int PW = $clog2(MAX_DELAY_SAMPLES);
    localparam int QW = 16 + PW;
    localparam int LEN_INIT = (fde_pkg::LEN_RESET > MAX_DELAY_SAMPLES) ?
                              MAX_DELAY_SAMPLES : fde_pkg::LEN_RESET;

    // ------------------------------------------------------------------
    // Configuration registers, saturated on write
    // ------------------------------------------------------------------
    logic [fde_pkg::LEN_W-1:0] r_len, n_len;
    logic [15:0]               r_mix, n_mix;
    logic [14:0]               r_fb, n_fb;
    fde_pkg::t_gains           gains;

    always_comb begin
        n_len = r_len;
        n_mix = r_mix;
        n_fb  = r_fb;
        if (i_cfg_we) begin
            case (i_cfg_index)
                fde_pkg::REG_LINE_LENGTH: begin
                    if (i_cfg_data == '0) begin
                        n_len = fde_pkg::LEN_W'(1);
                    end else if (32'(i_cfg_data) > MAX_DELAY_SAMPLES) begin
                        n_len = fde_pkg::LEN_W'(MAX_DELAY_SAMPLES);
                    end else begin
                        n_len = fde_pkg::LEN_W'(i_cfg_data);
                    end
                end
                fde_pkg::REG_MIX_GAIN: begin
                    if ({1'b0, i_cfg_data} > fde_pkg::MIX_FULL) begin
                        n_mix = 16'(fde_pkg::MIX_FULL);
                    end else begin
                        n_mix = i_cfg_data;
                    end
                end
                fde_pkg::REG_FEEDBACK_GAIN: begin
                    // register is 15 bits wide; the top data bit is dropped
                    if (i_cfg_data[14:0] > fde_pkg::FB_MAX) begin
                        n_fb = fde_pkg::FB_MAX;
                    end else begin
                        n_fb = i_cfg_data[14:0];
                    end
                end
                default: begin
                    // unused index: write ignored
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= fde_pkg::LEN_W'(LEN_INIT);
            r_mix <= fde_pkg::MIX_RESET;
            r_fb  <= fde_pkg::FB_RESET;
        end else begin
            r_len <= n_len;
            r_mix <= n_mix;
            r_fb  <= n_fb;
        end
    end

    assign gains.mix = r_mix;
    assign gains.fb  = r_fb;

    // ------------------------------------------------------------------
    // Front: pointer tagging
    // ------------------------------------------------------------------
    logic          q_push, q_pop, q_empty, q_full;
    logic [QW-1:0] q_wdata, q_rdata;
    logic [1:0]    q_count;

    fde_front #(
        .MAX_DELAY_SAMPLES (MAX_DELAY_SAMPLES)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_sample (i_sample_in),
        .i_len    (r_len),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_data (q_wdata)
    );

    assign full = q_full;

    // Decoupling queue between front and back
    fde_fifo #(
        .WIDTH (QW),
        .DEPTH (2)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty),
        .o_full  (q_full),
        .o_count (q_count)
    );

    // ------------------------------------------------------------------
    // Back: delay line access and mix
    // ------------------------------------------------------------------
    logic                          out_push, out_full;
    logic signed [15:0]            out_wdata;
    logic [15:0]                   out_rdata;
    logic [fde_pkg::OUT_CNT_W-1:0] out_count;

    fde_back #(
        .MAX_DELAY_SAMPLES (MAX_DELAY_SAMPLES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_data    (q_rdata),
        .o_q_pop     (q_pop),
        .i_gains     (gains),
        .i_out_count (out_count),
        .o_out_push  (out_push),
        .o_out_data  (out_wdata)
    );

    fde_fifo #(
        .WIDTH (16),
        .DEPTH (fde_pkg::OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (out_wdata),
        .i_pop   (pop),
        .o_data  (out_rdata),
        .o_empty (empty),
        .o_full  (out_full),
        .o_count (out_count)
    );

    assign o_sample_out = $signed(out_rdata);

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Result credit check: the back never pushes into a full result queue
    a_out_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_push |-> !out_full)
        else $error("result queue overflow");

    // The RAM port alternates read and write, so issues are spaced
    a_issue_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |=> !q_pop)
        else $error("back issued on consecutive cycles");

    // Every issued item is pushed into the result queue once it has passed stage 1 and stage 2
    a_issue_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> ##2 out_push)
        else $error("issued item did not produce a result");

    // Middle queue occupancy never exceeds its depth
    a_mid_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count != 2'd3)
        else $error("middle queue count out of range");

    // Line length never reads as zero
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len != '0)
        else $error("line length zero");

endmodule

[bench/tb_feedback_delay_echo_unit.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_feedback_delay_echo_unit
// Self-checking bench for the Q1.15 feedback delay-line echo unit.
// ============================================================================
// Each accepted item runs through a local echo model with its own delay
// line, pointer and gains. The model's output goes into a queue of pending
// samples, and every popped result is checked against the oldest one.
// Directed tests cover field extremes, register saturation, a line shortened
// under the pointer and an unused register index. A back-pressure test stalls
// the result side long enough to fill the unit. Random traffic then runs in
// three idling modes, with fresh register settings between blocks of items.
// ============================================================================
module tb_feedback_delay_echo_unit;

    localparam int LINE_DEPTH    = 32768;
    localparam int Q15_ONE       = 32768;
    localparam int FLUSH_CYCLES  = 8;     // margin over the result latency
    localparam int STALL_LIMIT   = 4000;  // cycles with no item moving either way
    localparam int BLOCK_ITEMS   = 50;
    localparam int BLOCKS_PER_MODE = 9;

    // Index 3 decodes to no register; writes there must be dropped.
    localparam logic [fde_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // ------------------------------------------------------------------------
    // DUT connections
    // ------------------------------------------------------------------------
    logic                            i_clk;
    logic                            i_rst_n;
    logic                            push;
    logic                            full;
    logic signed [15:0]              i_sample_in;
    logic                            empty;
    logic                            pop;
    logic signed [15:0]              o_sample_out;
    logic                            i_cfg_we;
    logic [fde_pkg::CFG_IDX_W-1:0]   i_cfg_index;
    logic [fde_pkg::CFG_DATA_W-1:0]  i_cfg_data;

    feedback_delay_echo_unit #(
        .MAX_DELAY_SAMPLES(LINE_DEPTH)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_sample_in  (i_sample_in),
        .empty        (empty),
        .pop          (pop),
        .o_sample_out (o_sample_out),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // Clock: 10 ns period
    // ------------------------------------------------------------------------
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------------
    // Echo model state; mirrors what the unit should hold after each item
    // ------------------------------------------------------------------------
    logic signed [15:0] echo_line [LINE_DEPTH];
    int                 line_pos;
    int                 line_len;
    int                 mix_gain;
    int                 fb_gain;

    logic signed [15:0] pending_echo [$];   // expected samples, oldest first

    int err_count;
    int quiet_cycles;     // cycles since the last item moved on either side
    int send_idle_pct;    // chance per cycle that the sender holds back
    int recv_idle_pct;    // chance per cycle that the receiver holds back
    int hold_left;        // long receiver stall, owned by the receiver process

    function automatic int clamp_q15(input int v);
        if (v > 32767) begin
            return 32767;
        end
        if (v < -32768) begin
            return -32768;
        end
        return v;
    endfunction

    function automatic void echo_reset();
        foreach (echo_line[k]) begin
            echo_line[k] = '0;
        end
        line_pos = 0;
        line_len = (fde_pkg::LEN_RESET > LINE_DEPTH) ? LINE_DEPTH : fde_pkg::LEN_RESET;
        mix_gain = int'(fde_pkg::MIX_RESET);
        fb_gain  = int'(fde_pkg::FB_RESET);
    endfunction

    // Saturating register write, as the unit applies it
    function automatic void echo_set_reg(input logic [fde_pkg::CFG_IDX_W-1:0] idx,
                                         input logic [fde_pkg::CFG_DATA_W-1:0] data);
        int v;
        case (idx)
            fde_pkg::REG_LINE_LENGTH: begin
                v = int'(data);
                if (v < 1) v = 1;
                if (v > LINE_DEPTH) v = LINE_DEPTH;
                line_len = v;
            end
            fde_pkg::REG_MIX_GAIN: begin
                v = int'(data);
                if (v > int'(fde_pkg::MIX_FULL)) v = int'(fde_pkg::MIX_FULL);
                mix_gain = v;
            end
            fde_pkg::REG_FEEDBACK_GAIN: begin
                v = int'(data[14:0]);
                if (v > int'(fde_pkg::FB_MAX)) v = int'(fde_pkg::FB_MAX);
                fb_gain = v;
            end
            default: ;
        endcase
    endfunction

    // One sample through the line: read, write back with feedback, mix out.
    // Products stay well inside 32 bits; >>> on int floors toward -inf.
    function automatic logic signed [15:0] echo_predict(input logic signed [15:0] x_in);
        int x;
        int delayed;
        int fb_part;
        int wr;
        int y;
        x       = int'(x_in);
        delayed = int'(echo_line[line_pos]);
        fb_part = (fb_gain * delayed) >>> 15;
        wr      = clamp_q15(x + fb_part);
        echo_line[line_pos] = wr[15:0];
        line_pos++;
        // also covers a length cut below the current position
        if (line_pos >= line_len) line_pos = 0;
        y = ((Q15_ONE - mix_gain) * x + mix_gain * delayed) >>> 15;
        return 16'(clamp_q15(y));
    endfunction

    // ------------------------------------------------------------------------
    // Receiver: random pop, plus an optional long hold-off
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_left > 0) begin
            pop <= 1'b0;
            hold_left--;
        end else begin
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Result check at the edge where the item is taken
    always @(posedge i_clk) begin
        logic signed [15:0] want;
        if (i_rst_n && pop && !empty) begin
            if (pending_echo.size() == 0) begin
                $error("sample_out: result %0d with no item pending", o_sample_out);
                err_count++;
            end else begin
                want = pending_echo.pop_front();
                if (o_sample_out !== want) begin
                    $error("sample_out: expected %0d, actual %0d", want, o_sample_out);
                    err_count++;
                end
            end
        end
    end

    // Activity tracking for the watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        @(posedge i_clk);
        while (quiet_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Shared driving tasks
    // ------------------------------------------------------------------------

    // Offer one item; returns right after the edge that took it.
    // push stays high so back-to-back items need no extra toggle.
    task automatic send_sample(input logic signed [15:0] x);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push        <= 1'b1;
        i_sample_in <= x;
        do begin
            @(posedge i_clk);
        end while (full);
        pending_echo.push_back(echo_predict(x));
    endtask

    // Stop sending, drain all results, let the pipeline go quiet
    task automatic drain_unit();
        @(negedge i_clk);
        push <= 1'b0;
        while (pending_echo.size() != 0) @(posedge i_clk);
        repeat (FLUSH_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [fde_pkg::CFG_IDX_W-1:0] idx,
                             input logic [fde_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        echo_set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Mostly full-range noise, with loud extremes and quiet passages
    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(9))
            0: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            1: return 16'($signed($urandom_range(511)) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Power-up settings: long line, half mix, half feedback
    task automatic test_reset_defaults();
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh0000);
        send_sample(-16'sd1);
    endtask

    // Zero length, over-range mix and feedback; then fully dry, no feedback
    task automatic test_gain_extremes();
        drain_unit();
        write_reg(fde_pkg::REG_LINE_LENGTH, 16'd0);          // stored as 1
        write_reg(fde_pkg::REG_MIX_GAIN, 16'hFFFF);          // stored as full wet
        write_reg(fde_pkg::REG_FEEDBACK_GAIN, 16'hFFFF);     // low 15 bits, capped at 0.99
        send_sample(16'sh7FFF);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        drain_unit();
        write_reg(fde_pkg::REG_MIX_GAIN, 16'd0);
        write_reg(fde_pkg::REG_FEEDBACK_GAIN, 16'h8000);     // bit 15 dropped -> 0
        send_sample(16'sd1);
        send_sample(16'sh8000);
    endtask

    // Lengths above the store depth are capped to the depth; an over-range mix to full wet
    task automatic test_length_limits();
        drain_unit();
        write_reg(fde_pkg::REG_LINE_LENGTH, 16'hFFFF);
        write_reg(fde_pkg::REG_MIX_GAIN, 16'd32769);
        send_sample(16'sh4000);
        send_sample(-16'sh4000);
        drain_unit();
        write_reg(fde_pkg::REG_LINE_LENGTH, 16'd32769);
        send_sample(16'sh7FFF);
    endtask

    // Pointer past the new length: current slot used once, then wrap
    task automatic test_shortened_line();
        drain_unit();
        write_reg(fde_pkg::REG_LINE_LENGTH, 16'd8);
        write_reg(fde_pkg::REG_MIX_GAIN, 16'd16384);
        write_reg(fde_pkg::REG_FEEDBACK_GAIN, 16'd32440);
        for (int k = 0; k < 6; k++) send_sample(rand_sample());
        drain_unit();
        write_reg(fde_pkg::REG_LINE_LENGTH, 16'd3);
        for (int k = 0; k < 3; k++) send_sample(rand_sample());
    endtask

    task automatic test_unused_register();
        drain_unit();
        write_reg(REG_UNUSED, 16'h0000);
        write_reg(REG_UNUSED, 16'hFFFF);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
    endtask

    // Receiver holds off while the sender keeps offering; full must rise
    task automatic test_backpressure();
        int saved_send;
        saved_send = send_idle_pct;
        drain_unit();
        write_reg(fde_pkg::REG_LINE_LENGTH, 16'd5);
        write_reg(fde_pkg::REG_FEEDBACK_GAIN, 16'd30000);
        send_idle_pct = 0;
        @(posedge i_clk);
        hold_left = 120;
        for (int k = 0; k < 40; k++) send_sample(rand_sample());
        send_idle_pct = saved_send;
    endtask

    // New random settings, mostly short lines so feedback builds up
    task automatic randomize_regs();
        logic [fde_pkg::CFG_DATA_W-1:0] len;
        logic [fde_pkg::CFG_DATA_W-1:0] mix;
        logic [fde_pkg::CFG_DATA_W-1:0] fbk;
        case ($urandom_range(19))
            0:       len = 16'd0;
            1:       len = 16'd32768;
            2:       len = 16'($urandom);
            3, 4:    len = 16'($urandom_range(600, 65));
            default: len = 16'($urandom_range(64, 1));
        endcase
        case ($urandom_range(9))
            0:       mix = 16'd0;
            1:       mix = 16'd32768;
            2:       mix = 16'($urandom);
            default: mix = 16'($urandom_range(32768));
        endcase
        case ($urandom_range(9))
            0:       fbk = 16'd0;
            1:       fbk = 16'hFFFF;
            2:       fbk = 16'($urandom);
            default: fbk = 16'($urandom_range(32440));
        endcase
        drain_unit();
        write_reg(fde_pkg::REG_LINE_LENGTH, len);
        write_reg(fde_pkg::REG_MIX_GAIN, mix);
        write_reg(fde_pkg::REG_FEEDBACK_GAIN, fbk);
        if ($urandom_range(7) == 0) write_reg(REG_UNUSED, 16'($urandom));
    endtask

    // Three idling modes: slow receiver, slow sender, then full speed
    task automatic test_random_traffic();
        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin send_idle_pct = 34; recv_idle_pct = 69; end
                1: begin send_idle_pct = 69; recv_idle_pct = 34; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int blk = 0; blk < BLOCKS_PER_MODE; blk++) begin
                randomize_regs();
                for (int k = 0; k < BLOCK_ITEMS; k++) send_sample(rand_sample());
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n       = 1'b0;
        push          = 1'b0;
        i_sample_in   = '0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        err_count     = 0;
        hold_left     = 0;
        send_idle_pct = 34;
        recv_idle_pct = 69;
        echo_reset();

        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_gain_extremes();
        test_length_limits();
        test_shortened_line();
        test_unused_register();
        test_backpressure();
        test_random_traffic();

        drain_unit();
        if (pending_echo.size() != 0) begin
            $error("sample_out: %0d results never arrived", pending_echo.size());
            err_count++;
        end
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
